@@ src/magma_pkg.sv @@
// ----------------------------------------------------------------------------
// Magma cipher package
// Widths, S-box table, key schedule and round function shared by the
// key register file, the round cells and the top level.
// ----------------------------------------------------------------------------
package magma_pkg;

    localparam int ROUNDS_DEF = 32;
    localparam int KEY_WORDS  = 8;
    localparam int KEY_IDX_W  = 3;
    localparam int HALF_W     = 32;
    localparam int BLOCK_W    = 64;
    localparam int ROT_AMT    = 11;
    localparam int CFG_IDX_W  = 4;
    localparam int NIBBLES    = 8;

    typedef logic [HALF_W-1:0] t_half;
    typedef t_half t_key_arr [KEY_WORDS];

    typedef struct packed {
        logic valid;
        logic decrypt;
    } t_cell_ctl;

    typedef logic [3:0] t_sbox_row [16];
    typedef t_sbox_row t_sbox [NIBBLES];

    localparam t_sbox SBOX = '{
        '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
          4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
        '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
          4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
        '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
          4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
        '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
          4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
        '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
          4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
        '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
          4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
        '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
          4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
        '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
          4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
    };

    // encryption key word for schedule slot r
    function automatic int key_index(input int r);
        int r5;
        r5 = r & 31;
        return (r5 < 24) ? (7 - (r5 & 7)) : (r5 & 7);
    endfunction

    function automatic t_half round_fn(input t_half half, input t_half rk);
        t_half t;
        t_half s;
        t = half + rk;
        s = '0;
        for (int k = 0; k < NIBBLES; k++) begin
            s[4*k +: 4] = SBOX[k][t[4*k +: 4]];
        end
        return {s[HALF_W-ROT_AMT-1:0], s[HALF_W-1:HALF_W-ROT_AMT]};
    endfunction

endpackage

@@ src/magma_block_cipher.sv @@
// ----------------------------------------------------------------------------
// Magma block cipher
// Takes one 64-bit block per clock and returns it encrypted or decrypted
// on o_block_out, marked by a one-cycle o_valid strobe. Each block passes
// through the row of registered round cells, one Feistel round per cell;
// busy stays low, so a new block may start in every cycle. Results cannot
// be held off and must be taken when o_valid is high. Key words must be
// written through the configuration port only while no block is in flight;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module magma_block_cipher #(
    parameter int ROUNDS = magma_pkg::ROUNDS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_opcode,
    input  logic [magma_pkg::BLOCK_W-1:0]   i_block_in,
    output logic                            o_valid,
    output logic [magma_pkg::BLOCK_W-1:0]   o_block_out,
    input  logic                            i_cfg_we,
    input  logic [magma_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [magma_pkg::HALF_W-1:0]    i_cfg_data
);
    import magma_pkg::*;

    t_key_arr  w_keys;
    t_cell_ctl w_ctl [ROUNDS+1];
    t_half     w_a   [ROUNDS+1];
    t_half     w_b   [ROUNDS+1];
    logic      w_accept;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    magma_key_regs u_keys (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_keys     (w_keys)
    );

    assign w_ctl[0].valid   = w_accept;
    assign w_ctl[0].decrypt = i_opcode;
    assign w_a[0]           = i_block_in[HALF_W-1:0];
    assign w_b[0]           = i_block_in[BLOCK_W-1:HALF_W];

    for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
        magma_round_cell #(
            .ROUNDS    (ROUNDS),
            .ROUND_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_keys  (w_keys),
            .i_ctl   (w_ctl[g]),
            .i_a     (w_a[g]),
            .i_b     (w_b[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_a     (w_a[g+1]),
            .o_b     (w_b[g+1])
        );
    end

    assign o_valid     = w_ctl[ROUNDS].valid;
    assign o_block_out = {w_a[ROUNDS], w_b[ROUNDS]};

`ifndef SYNTHESIS
    a_valid_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, ROUNDS))
        else $error("result beat without matching start");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_ctl[1].valid)
        else $error("accepted beat did not enter first cell");
    a_reset_flushes: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !w_ctl[1].valid)
        else $error("pipeline not flushed by reset");
`endif

endmodule

@@ src/magma_key_regs.sv @@
// ----------------------------------------------------------------------------
// Magma key register file
// Eight 32-bit key words written through the configuration port.
// ----------------------------------------------------------------------------
module magma_key_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [magma_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [magma_pkg::HALF_W-1:0]    i_cfg_data,
    output magma_pkg::t_key_arr             o_keys
);
    import magma_pkg::*;

    t_key_arr r_key;
    t_key_arr n_key;
    logic     w_hit;

    assign w_hit = i_cfg_we && (i_cfg_idx < CFG_IDX_W'(KEY_WORDS));

    always_comb begin
        n_key = r_key;
        if (w_hit) begin
            n_key[i_cfg_idx[KEY_IDX_W-1:0]] = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < KEY_WORDS; j++) begin
                r_key[j] <= '0;
            end
        end else begin
            r_key <= n_key;
        end
    end

    assign o_keys = r_key;

`ifndef SYNTHESIS
    a_write_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit |=> r_key[$past(i_cfg_idx[KEY_IDX_W-1:0])] == $past(i_cfg_data))
        else $error("key write lost");
    a_miss_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_hit |=> (r_key[0] == $past(r_key[0])) && (r_key[7] == $past(r_key[7])))
        else $error("key changed without write");
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_key[0] == '0) && (r_key[KEY_WORDS-1] == '0))
        else $error("key not cleared by reset");
`endif

endmodule

@@ src/magma_round_cell.sv @@
// ----------------------------------------------------------------------------
// Magma round cell
// One Feistel round with its own fixed encryption and decryption key slots; registers the beat.
// ----------------------------------------------------------------------------
module magma_round_cell #(
    parameter int ROUNDS    = magma_pkg::ROUNDS_DEF,
    parameter int ROUND_IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  magma_pkg::t_key_arr         i_keys,
    input  magma_pkg::t_cell_ctl        i_ctl,
    input  logic [magma_pkg::HALF_W-1:0] i_a,
    input  logic [magma_pkg::HALF_W-1:0] i_b,
    output magma_pkg::t_cell_ctl        o_ctl,
    output logic [magma_pkg::HALF_W-1:0] o_a,
    output logic [magma_pkg::HALF_W-1:0] o_b
);
    import magma_pkg::*;

    localparam int ENC_KEY = key_index(ROUND_IDX);
    localparam int DEC_KEY = key_index(ROUNDS - 1 - ROUND_IDX);

    t_cell_ctl r_ctl;
    t_half     r_a;
    t_half     r_b;
    t_half     n_a;
    t_half     w_rk;

    assign w_rk = i_ctl.decrypt ? i_keys[KEY_IDX_W'(DEC_KEY)] : i_keys[KEY_IDX_W'(ENC_KEY)];
    assign n_a  = round_fn(i_a, w_rk) ^ i_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= i_a;
    end

    assign o_ctl = r_ctl;
    assign o_a   = r_a;
    assign o_b   = r_b;

endmodule
